### rtl/core/wams_pkg.sv
// shared codes, limits and the result record of the weighted adjacency matrix store
`default_nettype none

package wams_pkg;

    localparam int NODES_REG_BITS = 5;
    localparam int NODE_BITS      = 4;
    localparam int OUT_W_BITS     = 16;
    localparam int EDGE_BITS      = 7;
    localparam int RESULT_CAP     = 16;
    localparam int CAP_BITS       = $clog2(RESULT_CAP + 1);

    localparam logic [NODES_REG_BITS-1:0] NODES_RESET = 5'd16;
    localparam logic [NODE_BITS-1:0]      DEGREE_MAX  = 4'd15;
    localparam logic [EDGE_BITS-1:0]      EDGE_MAX    = 7'd127;

    // register index, taken from paddr[2]
    localparam logic REG_NODES_IN_USE = 1'b0;

    localparam logic [1:0] CMD_ADD    = 2'd0;
    localparam logic [1:0] CMD_QUERY  = 2'd1;
    localparam logic [1:0] CMD_LIST   = 2'd2;
    localparam logic [1:0] CMD_DEGREE = 2'd3;

    localparam logic STATUS_OK     = 1'b0;
    localparam logic STATUS_REJECT = 1'b1;

    typedef struct packed {
        logic                  status;
        logic [OUT_W_BITS-1:0] weight;
        logic [NODE_BITS-1:0]  neighbor;
        logic                  found;
        logic [NODE_BITS-1:0]  degree;
        logic                  last;
    } t_result;

endpackage

`default_nettype wire

### rtl/core/weighted_adjacency_matrix_store_top.sv
// top level: weight matrix memory, command sequencer and configuration port
`default_nettype none

// Weighted adjacency matrix store. An item is taken when start is high and busy is low;
// busy stays high until the item's last result is on the ports. Results appear at most one per
// cycle, each for exactly one cycle while o_valid is high; there is no way to stall them.
// A command rejected at once never raises busy. Add edge does a check read, then one write
// for each direction, and is rejected when the check finds an edge already there. A listing
// or degree scan walks up to n row entries, n being the clamped node count (a listing stops
// after RESULT_CAP hits); the single read port fetches one row entry per cycle. For any item
// but one rejected at once, the item's last result is on the ports in the cycle at whose end
// the next item can be taken. Listing results are held back by one hit, so the final one can
// carry last. After reset the memory is cleared one entry per cycle, 4**ceil(log2(MAX_NODES))
// entries (256 at the defaults), with busy high; config writes still land.
module weighted_adjacency_matrix_store_top #(
    parameter int MAX_NODES   = 16,
    parameter int WEIGHT_BITS = 16
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  start,
    output      logic                                  busy,
    input  wire logic [1:0]                            i_cmd,
    input  wire logic [wams_pkg::NODE_BITS-1:0]        i_node_u,
    input  wire logic [wams_pkg::NODE_BITS-1:0]        i_node_v,
    input  wire logic [15:0]                           i_edge_weight,
    output      logic                                  o_valid,
    output      logic                                  o_status,
    output      logic [wams_pkg::OUT_W_BITS-1:0]       o_result_weight,
    output      logic [wams_pkg::NODE_BITS-1:0]        o_neighbor_node,
    output      logic                                  o_neighbor_found,
    output      logic [wams_pkg::NODE_BITS-1:0]        o_degree_count,
    output      logic [wams_pkg::EDGE_BITS-1:0]        o_edge_total,
    output      logic                                  o_last,
    input  wire logic                                  psel,
    input  wire logic                                  penable,
    input  wire logic                                  pwrite,
    input  wire logic [2:0]                            paddr,
    input  wire logic [31:0]                           pwdata,
    output      logic [31:0]                           prdata,
    output      logic                                  pready
);
    import wams_pkg::*;

    localparam int IW    = $clog2(MAX_NODES);
    localparam int AW    = 2 * IW;
    localparam int DEPTH = 1 << AW;
    localparam int NB    = $clog2(MAX_NODES + 1);
    localparam int CW    = (NB > NODES_REG_BITS) ? NB : NODES_REG_BITS;

    typedef enum logic [6:0] {
        S_CLEAR   = 7'b0000001,
        S_IDLE    = 7'b0000010,
        S_ADD_CHK = 7'b0000100,
        S_ADD_WR2 = 7'b0001000,
        S_QUERY   = 7'b0010000,
        S_SCAN    = 7'b0100000,
        S_FIN     = 7'b1000000
    } t_state;

    // weight memory, rows padded to a power of two
    logic [WEIGHT_BITS-1:0] r_mem [DEPTH];
    logic [WEIGHT_BITS-1:0] r_rdata;
    logic                   w_we;
    logic [AW-1:0]          w_waddr;
    logic [AW-1:0]          w_raddr;
    logic [WEIGHT_BITS-1:0] w_wdata;

    t_state                 r_state, n_state;
    logic [AW-1:0]          r_clr, n_clr;
    logic [IW-1:0]          r_u, n_u;
    logic [IW-1:0]          r_v, n_v;
    logic [WEIGHT_BITS-1:0] r_w, n_w;
    logic [CW-1:0]          r_col, n_col;
    logic [NODE_BITS-1:0]   r_deg, n_deg;
    logic [CAP_BITS-1:0]    r_k, n_k;
    logic                   r_pend, n_pend;
    logic [WEIGHT_BITS-1:0] r_pw, n_pw;
    logic [IW-1:0]          r_pn, n_pn;
    logic                   r_is_list, n_is_list;
    logic [EDGE_BITS-1:0]   r_edges, n_edges;
    logic [NODES_REG_BITS-1:0] r_nodes;
    logic                   r_valid, n_valid;
    t_result                r_res, n_res;

    logic [CW-1:0]          w_bound;
    logic [CW-1:0]          w_col_nx;
    logic                   w_u_ok;
    logic                   w_v_ok;
    logic [WEIGHT_BITS-1:0] w_in;
    logic                   w_hit;

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        r_rdata <= r_mem[w_raddr];
    end

    // effective node count, clamped to 1 .. MAX_NODES
    always_comb begin
        if (r_nodes == '0) begin
            w_bound = CW'(1);
        end else if (CW'(r_nodes) > CW'(MAX_NODES)) begin
            w_bound = CW'(MAX_NODES);
        end else begin
            w_bound = CW'(r_nodes);
        end
    end

    assign w_u_ok   = CW'(i_node_u) < w_bound;
    assign w_v_ok   = CW'(i_node_v) < w_bound;
    assign w_in     = WEIGHT_BITS'(i_edge_weight);
    assign w_col_nx = r_col + CW'(1);
    assign w_hit    = r_rdata != '0;

    always_comb begin
        n_state   = r_state;
        n_clr     = r_clr;
        n_u       = r_u;
        n_v       = r_v;
        n_w       = r_w;
        n_col     = r_col;
        n_deg     = r_deg;
        n_k       = r_k;
        n_pend    = r_pend;
        n_pw      = r_pw;
        n_pn      = r_pn;
        n_is_list = r_is_list;
        n_edges   = r_edges;
        n_valid   = 1'b0;
        n_res     = '0;
        w_we      = 1'b0;
        w_waddr   = r_clr;
        w_wdata   = '0;
        w_raddr   = '0;

        unique case (r_state)
            S_CLEAR: begin
                w_we  = 1'b1;
                n_clr = r_clr + AW'(1);
                if (r_clr == AW'(DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (start) begin
                    n_u       = IW'(i_node_u);
                    n_v       = IW'(i_node_v);
                    n_w       = w_in;
                    n_is_list = i_cmd == CMD_LIST;
                    n_col     = '0;
                    n_deg     = '0;
                    n_k       = '0;
                    n_pend    = 1'b0;
                    unique case (i_cmd)
                        CMD_ADD: begin
                            if (w_u_ok && w_v_ok && i_node_u != i_node_v && w_in != '0) begin
                                w_raddr = {IW'(i_node_u), IW'(i_node_v)};
                                n_state = S_ADD_CHK;
                            end else begin
                                n_valid      = 1'b1;
                                n_res.status = STATUS_REJECT;
                                n_res.last   = 1'b1;
                            end
                        end
                        CMD_QUERY: begin
                            if (w_u_ok && w_v_ok) begin
                                w_raddr = {IW'(i_node_u), IW'(i_node_v)};
                                n_state = S_QUERY;
                            end else begin
                                n_valid      = 1'b1;
                                n_res.status = STATUS_REJECT;
                                n_res.last   = 1'b1;
                            end
                        end
                        CMD_LIST, CMD_DEGREE: begin
                            if (w_u_ok) begin
                                w_raddr = {IW'(i_node_u), IW'(0)};
                                n_state = S_SCAN;
                            end else begin
                                n_valid      = 1'b1;
                                n_res.status = STATUS_REJECT;
                                n_res.last   = 1'b1;
                            end
                        end
                    endcase
                end
            end
            S_ADD_CHK: begin
                if (!w_hit) begin
                    w_we    = 1'b1;
                    w_waddr = {r_u, r_v};
                    w_wdata = r_w;
                    n_state = S_ADD_WR2;
                end else begin
                    n_valid      = 1'b1;
                    n_res.status = STATUS_REJECT;
                    n_res.last   = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            S_ADD_WR2: begin
                w_we    = 1'b1;
                w_waddr = {r_v, r_u};
                w_wdata = r_w;
                if (r_edges != EDGE_MAX) begin
                    n_edges = r_edges + EDGE_BITS'(1);
                end
                n_valid      = 1'b1;
                n_res.status = STATUS_OK;
                n_res.last   = 1'b1;
                n_state      = S_IDLE;
            end
            S_QUERY: begin
                n_valid      = 1'b1;
                n_res.status = STATUS_OK;
                n_res.weight = OUT_W_BITS'(r_rdata);
                n_res.last   = 1'b1;
                n_state      = S_IDLE;
            end
            S_SCAN: begin
                // r_rdata holds column r_col; fetch the next one
                w_raddr = {r_u, IW'(w_col_nx)};
                n_col   = w_col_nx;
                if (w_hit) begin
                    if (r_deg != DEGREE_MAX) begin
                        n_deg = r_deg + NODE_BITS'(1);
                    end
                    n_pw   = r_rdata;
                    n_pn   = IW'(r_col);
                    n_pend = 1'b1;
                    n_k    = r_k + CAP_BITS'(1);
                    // a new hit releases the one held back
                    if (r_pend && r_is_list) begin
                        n_valid         = 1'b1;
                        n_res.status    = STATUS_OK;
                        n_res.weight    = OUT_W_BITS'(r_pw);
                        n_res.neighbor  = NODE_BITS'(r_pn);
                        n_res.found     = 1'b1;
                    end
                end
                if (w_col_nx >= w_bound ||
                    (r_is_list && w_hit && r_k == CAP_BITS'(RESULT_CAP - 1))) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                n_valid      = 1'b1;
                n_res.status = STATUS_OK;
                n_res.last   = 1'b1;
                if (r_is_list) begin
                    if (r_pend) begin
                        n_res.weight   = OUT_W_BITS'(r_pw);
                        n_res.neighbor = NODE_BITS'(r_pn);
                        n_res.found    = 1'b1;
                    end
                end else begin
                    n_res.degree = r_deg;
                end
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_edges <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_edges <= n_edges;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_u       <= n_u;
        r_v       <= n_v;
        r_w       <= n_w;
        r_col     <= n_col;
        r_deg     <= n_deg;
        r_k       <= n_k;
        r_pend    <= n_pend;
        r_pw      <= n_pw;
        r_pn      <= n_pn;
        r_is_list <= n_is_list;
        r_res     <= n_res;
    end

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nodes <= NODES_RESET;
        end else if (psel && penable && pwrite && pready && paddr[2] == REG_NODES_IN_USE) begin
            r_nodes <= pwdata[NODES_REG_BITS-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_NODES_IN_USE) ? 32'(r_nodes) : 32'd0;

    assign busy             = r_state != S_IDLE;
    assign o_valid          = r_valid;
    assign o_status         = r_res.status;
    assign o_result_weight  = r_res.weight;
    assign o_neighbor_node  = r_res.neighbor;
    assign o_neighbor_found = r_res.found;
    assign o_degree_count   = r_res.degree;
    assign o_edge_total     = r_edges;
    assign o_last           = r_res.last;

endmodule

`default_nettype wire
